@@ rtl/core/acl_pkg.sv @@
// Shared types and constants for the alarm confirmation latch.
// Holds the status word bit map, register indexes and the result record.
// No dependencies.
package acl_pkg;

  // Width of the alarm bitmaps that leave the block.
  localparam int unsigned ALARM_W = 15;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned SUMMARY_W = 7;
  localparam int unsigned OUT_W = 2;
  localparam int unsigned TIME_W = 32;

  // Stream payload widths, rounded up to whole bytes.
  localparam int unsigned IN_DATA_W = 72;
  localparam int unsigned OUT_DATA_W = 64;

  // Input opcodes carried on the input tuser.
  localparam logic OP_EVAL  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Configuration register indexes (byte address / 4).
  localparam logic [2:0] REG_ENABLE_MASK = 3'd0;
  localparam logic [2:0] REG_CONFIRM_WINDOW = 3'd1;
  localparam logic [2:0] REG_OUTPUT_ROLE = 3'd2;
  localparam logic [2:0] REG_VOLTAGE_ARMED = 3'd3;
  localparam logic [2:0] REG_CURRENT_ARMED = 3'd4;

  // Enable mask bits.
  localparam int unsigned EN_OV = 0;
  localparam int unsigned EN_SAG = 1;
  localparam int unsigned EN_OC = 2;
  localparam int unsigned EN_PL = 3;
  localparam int unsigned EN_FREQ = 4;

  // Bit positions inside the meter status words.
  localparam int unsigned ST0_OV_LSB = 10;
  localparam int unsigned ST0_OC_LSB = 13;
  localparam int unsigned ST1_SAG_LSB = 12;
  localparam int unsigned ST1_PL_LSB = 8;
  localparam int unsigned ST1_FH_BIT = 15;
  localparam int unsigned ST1_FL_BIT = 11;

  // Alarm bitmap layout: OV 0-2, OC 3-5, UV 6-8, PL 9-11, FH 12, FL 13, IC 14.
  localparam int unsigned ALM_OV_LSB = 0;
  localparam int unsigned ALM_OC_LSB = 3;
  localparam int unsigned ALM_UV_LSB = 6;
  localparam int unsigned ALM_PL_LSB = 9;
  localparam int unsigned ALM_FH_BIT = 12;
  localparam int unsigned ALM_FL_BIT = 13;
  localparam int unsigned ALM_IC_BIT = 14;

  localparam logic [ALARM_W-1:0] GRP_OV_MASK = 15'h0007;
  localparam logic [ALARM_W-1:0] GRP_OC_MASK = 15'h0038;
  localparam logic [ALARM_W-1:0] GRP_UV_MASK = 15'h01C0;
  localparam logic [ALARM_W-1:0] GRP_PL_MASK = 15'h0E00;

  // Per-item control shared by the timer lanes and the merge stage.
  typedef struct packed {
    logic accept;  // an input item is transferred this cycle
    logic stop;    // clear or engineering mode: all timers stop
    logic clear;   // clear latches and outputs
    logic eval;    // evaluate the snapshot
  } acl_ctl_t;

  // One result item.
  typedef struct packed {
    logic [OUT_W-1:0]     sw_off;
    logic [OUT_W-1:0]     sw_on;
    logic [OUT_W-1:0]     driven;
    logic [SUMMARY_W-1:0] summary;
    logic [COUNT_W-1:0]   count;
    logic [ALARM_W-1:0]   newly;
    logic [ALARM_W-1:0]   latched;
    logic [ALARM_W-1:0]   active;
  } acl_result_t;

endpackage

@@ rtl/core/acl_lane.sv @@
// One confirmation timer lane: tracks first sighting of a single alarm.
// Depends on acl_pkg for the control record and time width.
module acl_lane (
  input  logic                         clk,
  input  logic                         rst_n,
  input  acl_pkg::acl_ctl_t            ctl,
  input  logic                         act_bit,
  input  logic [acl_pkg::TIME_W-1:0]   now_ms,
  input  logic [acl_pkg::TIME_W-1:0]   window_ms,
  output logic                         confirm
);
  import acl_pkg::*;

  logic              running_r;
  logic              running_nxt;
  logic [TIME_W-1:0] first_r;
  logic [TIME_W-1:0] elapsed;

  // Wrapping elapsed time since the first sighting.
  assign elapsed = now_ms - first_r;
  assign confirm = act_bit && running_r && (elapsed >= window_ms);

  // Run flag: set at first sighting, cleared by stop or when the condition is gone.
  always_comb begin
    running_nxt = running_r;
    if (ctl.accept) begin
      if (ctl.stop) begin
        running_nxt = 1'b0;
      end else begin
        running_nxt = act_bit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
    end else begin
      running_r <= running_nxt;
    end
  end

  // Capture the time of the first sighting.
  always_ff @(posedge clk) begin
    if (ctl.accept && ctl.eval && act_bit && !running_r) begin
      first_r <= now_ms;
    end
  end

endmodule

@@ rtl/core/acl_merge.sv @@
// Merge stage: combines lane confirmations into latches, outputs and summary.
// Depends on acl_pkg for the control record and result layout.
module acl_merge #(
  parameter int unsigned NUM_OUTPUTS = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  acl_pkg::acl_ctl_t             ctl,
  input  logic [acl_pkg::ALARM_W-1:0]   act,
  input  logic [acl_pkg::ALARM_W-1:0]   confirm,
  input  logic [acl_pkg::OUT_W-1:0]     role_mask,
  output acl_pkg::acl_result_t          result
);
  import acl_pkg::*;

  // Outputs that exist and can carry a role.
  localparam logic [OUT_W-1:0] OUT_LANE_MASK =
    (NUM_OUTPUTS >= OUT_W) ? {OUT_W{1'b1}} : OUT_W'((1 << NUM_OUTPUTS) - 1);

  logic [ALARM_W-1:0] latched_r, latched_nxt;
  logic [ALARM_W-1:0] active_r, active_nxt;
  logic [OUT_W-1:0]   driven_r, driven_nxt;
  logic [ALARM_W-1:0] newly;
  logic [OUT_W-1:0]   sw_on;
  logic [OUT_W-1:0]   sw_off;
  logic [COUNT_W-1:0] count;
  logic [SUMMARY_W-1:0] summary;

  // Latch update and output switching for the current item.
  always_comb begin
    newly       = '0;
    sw_on       = '0;
    sw_off      = '0;
    latched_nxt = latched_r;
    active_nxt  = active_r;
    driven_nxt  = driven_r;
    if (ctl.clear) begin
      sw_off      = driven_r;
      latched_nxt = '0;
      driven_nxt  = '0;
    end else if (ctl.eval) begin
      active_nxt  = act;
      newly       = confirm & ~latched_r;
      latched_nxt = latched_r | confirm;
      if (newly != '0) begin
        sw_on = role_mask & OUT_LANE_MASK & ~driven_r;
      end
      driven_nxt = driven_r | sw_on;
    end
  end

  // Population count of the new latch set.
  always_comb begin
    count = '0;
    for (int i = 0; i < ALARM_W; i++) begin
      count = count + COUNT_W'(latched_nxt[i]);
    end
  end

  // One warning bit per alarm group.
  always_comb begin
    summary    = '0;
    summary[0] = |(latched_nxt & GRP_OV_MASK);
    summary[1] = |(latched_nxt & GRP_UV_MASK);
    summary[2] = |(latched_nxt & GRP_OC_MASK);
    summary[3] = |(latched_nxt & GRP_PL_MASK);
    summary[4] = latched_nxt[ALM_FH_BIT];
    summary[5] = latched_nxt[ALM_FL_BIT];
    summary[6] = latched_nxt[ALM_IC_BIT];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latched_r <= '0;
      active_r  <= '0;
      driven_r  <= '0;
    end else if (ctl.accept) begin
      latched_r <= latched_nxt;
      active_r  <= active_nxt;
      driven_r  <= driven_nxt;
    end
  end

  assign result.active  = active_nxt;
  assign result.latched = latched_nxt;
  assign result.newly   = newly;
  assign result.count   = count;
  assign result.summary = summary;
  assign result.driven  = driven_nxt;
  assign result.sw_on   = sw_on;
  assign result.sw_off  = sw_off;

  // A clear leaves no latch and no driven output behind.
  a_clear_drops: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.accept && ctl.clear |=> latched_r == '0 && driven_r == '0)
    else $error("latches or outputs survived a clear");

  // Outputs without a role lane are never driven.
  a_no_phantom_output: assert property (@(posedge clk) disable iff (!rst_n)
    (driven_r & ~OUT_LANE_MASK) == '0)
    else $error("nonexistent output driven");

  // Every newly latched alarm stays latched after the transfer.
  a_newly_kept: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.accept && ctl.eval |=> ($past(newly) & ~latched_r) == '0)
    else $error("newly latched alarm not held");

endmodule

@@ rtl/core/acl_skid.sv @@
// Output register with a skid entry for the result stream.
// Depends on acl_pkg for the result record.
module acl_skid (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  acl_pkg::acl_result_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output acl_pkg::acl_result_t  out_data
);
  import acl_pkg::*;

  logic        out_valid_r;
  logic        skid_valid_r;
  acl_result_t out_data_r;
  acl_result_t skid_data_r;

  assign in_ready  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Valid flags: the skid entry fills only when the output holds a stalled result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_ready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_valid;
      end
    end else if (in_valid && in_ready) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload moves without reset.
  always_ff @(posedge clk) begin
    if (out_ready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (in_valid) begin
        out_data_r <= in_data;
      end
    end else if (in_valid && in_ready) begin
      skid_data_r <= in_data;
    end
  end

endmodule

@@ rtl/core/alarm_confirm_latch.sv @@
// Alarm confirmation latch: one registered result per snapshot or clear item.
// One item per cycle while in_tready is high; one 32-bit subtract-compare timer lane per alarm.
// Each result goes to the output register; a stalled output holds one more item in a skid entry.
// Synchronous active-low reset clears registers, latches, run flags and driven outputs;
// first-sighting times are not reset and are read only while their run flag is set.
// Depends on acl_pkg, acl_lane, acl_merge and acl_skid.
module alarm_confirm_latch #(
  parameter int unsigned NUM_ALARMS  = 15,
  parameter int unsigned NUM_OUTPUTS = 2
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input stream.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata: status_word0[15:0], status_word1[31:16], ic_fault[32],
  // engineering_mode[33], now_ms[65:34], zero fill[71:66]
  input  logic [acl_pkg::IN_DATA_W-1:0]     in_tdata,
  // tuser: opcode[0]
  input  logic                              in_tuser,
  // Result stream.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tdata: active_bits[14:0], latched_bits[29:15], newly_latched[44:30],
  // latched_count[48:45], warning_summary[55:49], outputs_driven[57:56],
  // outputs_switched_on[59:58], outputs_switched_off[61:60], zero fill[63:62]
  output logic [acl_pkg::OUT_DATA_W-1:0]    out_tdata,
  // Configuration port.
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [4:0]                        cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);
  import acl_pkg::*;

  // Configuration registers.
  logic [4:0]        enable_mask_r;
  logic [TIME_W-1:0] window_r;
  logic [OUT_W-1:0]  role_mask_r;
  logic              voltage_armed_r;
  logic              current_armed_r;
  logic              cfg_write;
  logic [2:0]        cfg_index;

  // Input fields.
  logic              opcode;
  logic [15:0]       status_word0;
  logic [15:0]       status_word1;
  logic              ic_fault;
  logic              engineering_mode;
  logic [TIME_W-1:0] now_ms;

  acl_ctl_t              ctl;
  logic [ALARM_W-1:0]    act;
  logic [NUM_ALARMS-1:0] lane_act;
  logic [NUM_ALARMS-1:0] lane_confirm;
  acl_result_t           result;
  acl_result_t           out_result;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_index  = cfg_paddr[4:2];

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_mask_r   <= '0;
      window_r        <= '0;
      role_mask_r     <= '0;
      voltage_armed_r <= 1'b0;
      current_armed_r <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ENABLE_MASK:    enable_mask_r   <= cfg_pwdata[4:0];
        REG_CONFIRM_WINDOW: window_r        <= cfg_pwdata;
        REG_OUTPUT_ROLE:    role_mask_r     <= cfg_pwdata[OUT_W-1:0];
        REG_VOLTAGE_ARMED:  voltage_armed_r <= cfg_pwdata[0];
        REG_CURRENT_ARMED:  current_armed_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (cfg_index)
      REG_ENABLE_MASK:    cfg_prdata = {27'd0, enable_mask_r};
      REG_CONFIRM_WINDOW: cfg_prdata = window_r;
      REG_OUTPUT_ROLE:    cfg_prdata = {30'd0, role_mask_r};
      REG_VOLTAGE_ARMED:  cfg_prdata = {31'd0, voltage_armed_r};
      REG_CURRENT_ARMED:  cfg_prdata = {31'd0, current_armed_r};
      default:            cfg_prdata = '0;
    endcase
  end

  // Unpack the input item.
  assign opcode           = in_tuser;
  assign status_word0     = in_tdata[15:0];
  assign status_word1     = in_tdata[31:16];
  assign ic_fault         = in_tdata[32];
  assign engineering_mode = in_tdata[33];
  assign now_ms           = in_tdata[65:34];

  // Item control shared by the lanes and the merge stage.
  always_comb begin
    ctl.accept = in_tvalid && in_tready;
    ctl.clear  = (opcode == OP_CLEAR);
    ctl.stop   = (opcode == OP_CLEAR) || engineering_mode;
    ctl.eval   = (opcode == OP_EVAL) && !engineering_mode;
  end

  // Decode the alarm conditions from the status words and the IC fault flag.
  always_comb begin
    act = '0;
    if (voltage_armed_r) begin
      if (enable_mask_r[EN_OV]) begin
        act[ALM_OV_LSB +: 3] = status_word0[ST0_OV_LSB +: 3];
      end
      if (enable_mask_r[EN_SAG]) begin
        act[ALM_UV_LSB +: 3] = status_word1[ST1_SAG_LSB +: 3];
      end
      if (enable_mask_r[EN_PL]) begin
        act[ALM_PL_LSB +: 3] = status_word1[ST1_PL_LSB +: 3];
      end
      if (enable_mask_r[EN_FREQ]) begin
        act[ALM_FH_BIT] = status_word1[ST1_FH_BIT];
        act[ALM_FL_BIT] = status_word1[ST1_FL_BIT];
      end
    end
    if (enable_mask_r[EN_OC] && current_armed_r) begin
      act[ALM_OC_LSB +: 3] = status_word0[ST0_OC_LSB +: 3];
    end
    act[ALM_IC_BIT] = ic_fault;
  end

  // One timer lane per alarm; lanes past the reported bitmap never see a condition.
  for (genvar b = 0; b < NUM_ALARMS; b++) begin : g_lane
    if (b < ALARM_W) begin : g_used
      assign lane_act[b] = act[b];
    end else begin : g_spare
      assign lane_act[b] = 1'b0;
    end

    acl_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .act_bit   (lane_act[b]),
      .now_ms    (now_ms),
      .window_ms (window_r),
      .confirm   (lane_confirm[b])
    );
  end

  acl_merge #(
    .NUM_OUTPUTS (NUM_OUTPUTS)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .act       (act),
    .confirm   (lane_confirm[ALARM_W-1:0]),
    .role_mask (role_mask_r),
    .result    (result)
  );

  acl_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (result),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_result)
  );

  // Pack the result, first field in the low bits.
  assign out_tdata = {2'b00,
                      out_result.sw_off,
                      out_result.sw_on,
                      out_result.driven,
                      out_result.summary,
                      out_result.count,
                      out_result.newly,
                      out_result.latched,
                      out_result.active};

  // The skid entry only fills behind a held output.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    u_skid.skid_valid_r |-> out_tvalid)
    else $error("skid entry filled while output empty");

  // A transfer while the output is stalled leaves the input side closed next cycle.
  a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && out_tvalid && !out_tready |=> !in_tready)
    else $error("stalled transfer did not occupy the skid entry");

endmodule
